@@ rtl/ssdb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssdb_pkg
// Types and codes shared by the span shape decoder front end, queue and
// back end.
// ----------------------------------------------------------------------------
package ssdb_pkg;

    localparam logic [1:0] KIND_SPAN    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_TRUNC   = 2'd2;
    localparam logic [1:0] KIND_UNDER   = 2'd3;

    localparam logic [7:0] END_MARK = 8'hFF;

    localparam int BASE_W = 17;

    typedef struct packed {
        logic [1:0]        kind;
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic [7:0]        width;
        logic [7:0]        offset;
        logic              pad_nz;
        logic [7:0]        color;
        logic [BASE_W-1:0] base;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/ssdb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssdb_front
// Byte parser: walks the shape layout, keeps the row pointer as a full value
// and as quotient/remainder by the view width, and queues span, summary and
// error commands.
// ----------------------------------------------------------------------------
module ssdb_front
    import ssdb_pkg::*;
#(
    parameter int VIEW_WIDTH = 320
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic [7:0]  data_byte,
    input  wire logic        buffer_end,
    input  wire logic        queue_full,
    output logic             push_valid,
    output cmd_t             push_cmd
);

    localparam int RW      = $clog2(VIEW_WIDTH + 1);
    localparam int LOGW    = $clog2(VIEW_WIDTH);
    localparam int SHIFT   = BASE_W + LOGW;
    localparam int MULT    = ((1 << SHIFT) + VIEW_WIDTH - 1) / VIEW_WIDTH;
    localparam int MW      = 19;
    localparam int PW      = SHIFT + BASE_W;

    localparam logic [MW-1:0]     MULT_C = MW'(MULT);
    localparam logic [RW-1:0]     W_R    = RW'(VIEW_WIDTH);
    localparam logic [BASE_W-1:0] W_B    = BASE_W'(VIEW_WIDTH);

    localparam logic [2:0] PH_COLOR   = 3'd0;
    localparam logic [2:0] PH_BASE_LO = 3'd1;
    localparam logic [2:0] PH_BASE_HI = 3'd2;
    localparam logic [2:0] PH_OFFSET  = 3'd3;
    localparam logic [2:0] PH_WIDTH   = 3'd4;
    localparam logic [2:0] PH_PAD     = 3'd5;

    logic [2:0]        phase_reg, phase_next;
    logic [15:0]       screen_base_reg;
    logic              dec1_reg, dec2_reg;
    logic [7:0]        lo_reg, lo_next;
    logic [7:0]        color_reg, color_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [7:0]        off_reg, off_next;
    logic [7:0]        wid_reg, wid_next;
    logic [31:0]       row_full_reg, row_full_next;
    logic [15:0]       row_q_reg, row_q_next;
    logic [RW-1:0]     row_r_reg, row_r_next;
    logic [PW-1:0]     prod_reg;

    logic              accept;
    logic [15:0]       off_q_tab [256];
    logic [RW-1:0]     off_r_tab [256];
    logic [15:0]       off_q;
    logic [RW-1:0]     off_r;
    logic              borrow;
    logic [RW-1:0]     span_x;
    logic [15:0]       span_y;
    logic [32:0]       row_sum;
    logic [BASE_W-1:0] dec_q;
    logic [BASE_W-1:0] dec_qw;
    logic [BASE_W-1:0] dec_r;

    for (genvar i = 0; i < 256; i++)
    begin : g_off_tab
        assign off_q_tab[i] = 16'(i / VIEW_WIDTH);
        assign off_r_tab[i] = RW'(i % VIEW_WIDTH);
    end

    assign accept = in_valid && !queue_full;
    assign off_q  = off_q_tab[off_reg];
    assign off_r  = off_r_tab[off_reg];
    assign borrow = row_r_reg < off_r;
    assign span_x = borrow ? (row_r_reg + W_R - off_r) : (row_r_reg - off_r);
    assign span_y = row_q_reg - off_q - 16'(borrow);
    assign row_sum = {1'b0, row_full_reg} + 33'(VIEW_WIDTH);

    assign dec_q  = prod_reg[PW-1 -: BASE_W];
    assign dec_qw = dec_q * W_B;
    assign dec_r  = base_reg - dec_qw;

    always_comb
    begin
        phase_next    = phase_reg;
        lo_next       = lo_reg;
        color_next    = color_reg;
        base_next     = base_reg;
        off_next      = off_reg;
        wid_next      = wid_reg;
        row_full_next = row_full_reg;
        row_q_next    = row_q_reg;
        row_r_next    = row_r_reg;
        push_valid    = 1'b0;
        push_cmd      = '0;

        if (dec2_reg)
        begin
            row_q_next = dec_q[15:0];
            row_r_next = dec_r[RW-1:0];
        end

        if (accept)
        begin
            case (phase_reg)
                PH_COLOR:
                begin
                    color_next = data_byte;
                    phase_next = PH_BASE_LO;
                end
                PH_BASE_LO:
                begin
                    lo_next    = data_byte;
                    phase_next = PH_BASE_HI;
                end
                PH_BASE_HI:
                begin
                    base_next     = BASE_W'(screen_base_reg) + BASE_W'({data_byte, lo_reg});
                    row_full_next = 32'(base_next);
                    phase_next    = PH_OFFSET;
                end
                PH_OFFSET:
                begin
                    if (data_byte == END_MARK)
                    begin
                        push_valid     = 1'b1;
                        push_cmd.kind  = KIND_SUMMARY;
                        push_cmd.color = color_reg;
                        push_cmd.base  = base_reg;
                        phase_next     = PH_COLOR;
                    end
                    else
                    begin
                        off_next   = data_byte;
                        phase_next = PH_WIDTH;
                    end
                end
                PH_WIDTH:
                begin
                    wid_next   = data_byte;
                    phase_next = PH_PAD;
                end
                PH_PAD:
                begin
                    if (row_full_reg < 32'(off_reg))
                    begin
                        push_valid    = 1'b1;
                        push_cmd.kind = KIND_UNDER;
                        phase_next    = PH_COLOR;
                    end
                    else if (!buffer_end)
                    begin
                        push_valid      = 1'b1;
                        push_cmd.kind   = KIND_SPAN;
                        push_cmd.pos_x  = 16'(span_x);
                        push_cmd.pos_y  = span_y;
                        push_cmd.width  = wid_reg;
                        push_cmd.offset = off_reg;
                        push_cmd.pad_nz = data_byte != 8'd0;
                        row_full_next   = row_sum[31:0];
                        if (row_sum[32])
                        begin
                            row_q_next = 16'd0;
                            row_r_next = row_sum[RW-1:0];
                        end
                        else
                        begin
                            row_q_next = row_q_reg + 16'd1;
                        end
                        phase_next = PH_OFFSET;
                    end
                end
                default:
                begin
                    phase_next = PH_COLOR;
                end
            endcase

            // truncation: end of buffer on anything but the terminator
            if (buffer_end && !push_valid && phase_reg != PH_OFFSET
                && phase_reg <= PH_PAD)
            begin
                push_valid    = 1'b1;
                push_cmd      = '0;
                push_cmd.kind = KIND_TRUNC;
                phase_next    = PH_COLOR;
            end
            else if (buffer_end && phase_reg == PH_OFFSET && data_byte != END_MARK)
            begin
                push_valid    = 1'b1;
                push_cmd      = '0;
                push_cmd.kind = KIND_TRUNC;
                phase_next    = PH_COLOR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_COLOR;
            screen_base_reg <= 16'd0;
            dec1_reg        <= 1'b0;
            dec2_reg        <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            dec1_reg  <= accept && (phase_reg == PH_BASE_HI);
            dec2_reg  <= dec1_reg;
            if (cfg_valid)
            begin
                screen_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        color_reg    <= color_next;
        base_reg     <= base_next;
        off_reg      <= off_next;
        wid_reg      <= wid_next;
        row_full_reg <= row_full_next;
        row_q_reg    <= row_q_next;
        row_r_reg    <= row_r_next;
        if (dec1_reg)
        begin
            prod_reg <= PW'(base_reg) * PW'(MULT_C);
        end
    end

endmodule
`default_nettype wire

@@ rtl/ssdb_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssdb_queue
// Two-entry command queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module ssdb_queue
    import ssdb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push_valid) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ssdb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ssdb_back
// Result stage: updates bounding box and counters per span and drives the
// registered output word.
// ----------------------------------------------------------------------------
module ssdb_back
    import ssdb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  wire cmd_t         head_cmd,
    output logic              pop,
    input  wire logic         out_stall,
    output logic              out_valid,
    output logic [1:0]        kind,
    output logic [15:0]       pos_x,
    output logic [15:0]       pos_y,
    output logic [7:0]        span_width,
    output logic [7:0]        span_offset,
    output logic [15:0]       box_max_x,
    output logic [15:0]       box_max_y,
    output logic              box_valid,
    output logic [7:0]        shape_color,
    output logic [BASE_W-1:0] base_pointer,
    output logic [15:0]       span_total,
    output logic [15:0]       padding_nonzero
);

    logic        out_valid_reg, out_valid_next;
    logic [15:0] span_cnt_reg, span_cnt_next;
    logic [15:0] pad_cnt_reg, pad_cnt_next;
    logic [15:0] min_x_reg, min_x_next;
    logic [15:0] max_x_reg, max_x_next;
    logic [15:0] min_y_reg, min_y_next;
    logic [15:0] max_y_reg, max_y_next;
    logic        seen_reg, seen_next;

    logic [1:0]        kind_reg, kind_next;
    logic [15:0]       pos_x_reg, pos_x_next;
    logic [15:0]       pos_y_reg, pos_y_next;
    logic [7:0]        width_reg, width_next;
    logic [7:0]        offset_reg, offset_next;
    logic [15:0]       bmax_x_reg, bmax_x_next;
    logic [15:0]       bmax_y_reg, bmax_y_next;
    logic              bvalid_reg, bvalid_next;
    logic [7:0]        color_reg, color_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [15:0]       total_reg, total_next;
    logic [15:0]       padnz_reg, padnz_next;

    logic [15:0] x1;

    assign pop = head_valid && (!out_valid_reg || !out_stall);
    assign x1  = head_cmd.pos_x + 16'(head_cmd.width) - 16'd1;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        span_cnt_next  = span_cnt_reg;
        pad_cnt_next   = pad_cnt_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        seen_next      = seen_reg;
        kind_next      = head_cmd.kind;
        pos_x_next     = 16'd0;
        pos_y_next     = 16'd0;
        width_next     = 8'd0;
        offset_next    = 8'd0;
        bmax_x_next    = 16'd0;
        bmax_y_next    = 16'd0;
        bvalid_next    = 1'b0;
        color_next     = 8'd0;
        base_next      = '0;
        total_next     = 16'd0;
        padnz_next     = 16'd0;

        if (pop)
        begin
            out_valid_next = 1'b1;
            case (head_cmd.kind)
                KIND_SPAN:
                begin
                    pos_x_next  = head_cmd.pos_x;
                    pos_y_next  = head_cmd.pos_y;
                    width_next  = head_cmd.width;
                    offset_next = head_cmd.offset;
                    if (span_cnt_reg != 16'hFFFF)
                    begin
                        span_cnt_next = span_cnt_reg + 16'd1;
                    end
                    if (head_cmd.pad_nz && pad_cnt_reg != 16'hFFFF)
                    begin
                        pad_cnt_next = pad_cnt_reg + 16'd1;
                    end
                    if (head_cmd.width != 8'd0)
                    begin
                        seen_next = 1'b1;
                        if (!seen_reg)
                        begin
                            min_x_next = head_cmd.pos_x;
                            max_x_next = x1;
                            min_y_next = head_cmd.pos_y;
                            max_y_next = head_cmd.pos_y;
                        end
                        else
                        begin
                            if (head_cmd.pos_x < min_x_reg)
                            begin
                                min_x_next = head_cmd.pos_x;
                            end
                            if (x1 > max_x_reg)
                            begin
                                max_x_next = x1;
                            end
                            if (head_cmd.pos_y < min_y_reg)
                            begin
                                min_y_next = head_cmd.pos_y;
                            end
                            if (head_cmd.pos_y > max_y_reg)
                            begin
                                max_y_next = head_cmd.pos_y;
                            end
                        end
                    end
                end
                KIND_SUMMARY:
                begin
                    pos_x_next    = min_x_reg;
                    pos_y_next    = min_y_reg;
                    bmax_x_next   = max_x_reg;
                    bmax_y_next   = max_y_reg;
                    bvalid_next   = seen_reg;
                    color_next    = head_cmd.color;
                    base_next     = head_cmd.base;
                    total_next    = span_cnt_reg;
                    padnz_next    = pad_cnt_reg;
                    span_cnt_next = 16'd0;
                    pad_cnt_next  = 16'd0;
                    min_x_next    = 16'd0;
                    max_x_next    = 16'd0;
                    min_y_next    = 16'd0;
                    max_y_next    = 16'd0;
                    seen_next     = 1'b0;
                end
                default:
                begin
                    span_cnt_next = 16'd0;
                    pad_cnt_next  = 16'd0;
                    min_x_next    = 16'd0;
                    max_x_next    = 16'd0;
                    min_y_next    = 16'd0;
                    max_y_next    = 16'd0;
                    seen_next     = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            span_cnt_reg  <= 16'd0;
            pad_cnt_reg   <= 16'd0;
            min_x_reg     <= 16'd0;
            max_x_reg     <= 16'd0;
            min_y_reg     <= 16'd0;
            max_y_reg     <= 16'd0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            span_cnt_reg  <= span_cnt_next;
            pad_cnt_reg   <= pad_cnt_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= kind_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            width_reg  <= width_next;
            offset_reg <= offset_next;
            bmax_x_reg <= bmax_x_next;
            bmax_y_reg <= bmax_y_next;
            bvalid_reg <= bvalid_next;
            color_reg  <= color_next;
            base_reg   <= base_next;
            total_reg  <= total_next;
            padnz_reg  <= padnz_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign span_width      = width_reg;
    assign span_offset     = offset_reg;
    assign box_max_x       = bmax_x_reg;
    assign box_max_y       = bmax_y_reg;
    assign box_valid       = bvalid_reg;
    assign shape_color     = color_reg;
    assign base_pointer    = base_reg;
    assign span_total      = total_reg;
    assign padding_nonzero = padnz_reg;

endmodule
`default_nettype wire

@@ rtl/span_shape_decoder_bbox.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// span_shape_decoder_bbox
// Shape span decoder with bounding box, span and padding statistics.
// Throughput: one byte per cycle; in_stall rises only when the two-entry
// command queue is full, which can happen only after the output has stalled.
// A result word passes from its queue entry register to the registered output
// word; out_stall can hold it in the queue.
// Reset: asynchronous, active low; parser awaits a color byte, counters,
// box and screen_base clear to zero, queue and output empty.
// ----------------------------------------------------------------------------
module span_shape_decoder_bbox
    import ssdb_pkg::*;
#(
    parameter int VIEW_WIDTH = 320
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [7:0]   data_byte,
    input  wire logic         buffer_end,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [1:0]        kind,
    output logic [15:0]       pos_x,
    output logic [15:0]       pos_y,
    output logic [7:0]        span_width,
    output logic [7:0]        span_offset,
    output logic [15:0]       box_max_x,
    output logic [15:0]       box_max_y,
    output logic              box_valid,
    output logic [7:0]        shape_color,
    output logic [BASE_W-1:0] base_pointer,
    output logic [15:0]       span_total,
    output logic [15:0]       padding_nonzero
);

    logic queue_full;
    logic push_valid;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;

    ssdb_front #(
        .VIEW_WIDTH (VIEW_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    ssdb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ssdb_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (pop),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .kind            (kind),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .span_width      (span_width),
        .span_offset     (span_offset),
        .box_max_x       (box_max_x),
        .box_max_y       (box_max_y),
        .box_valid       (box_valid),
        .shape_color     (shape_color),
        .base_pointer    (base_pointer),
        .span_total      (span_total),
        .padding_nonzero (padding_nonzero)
    );

endmodule
`default_nettype wire
